// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SRRW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srrw check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SRRW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srrw check failed");

`endif

// File: rtl/core/srrw_pkg.sv
// Types and constants for the selective-repeat receive window.
package srrw_pkg;

    localparam int SEQ_W  = 8;
    localparam int WORD_W = 32;
    localparam int SIZE_W = 11;
    localparam int WS_W   = 5;

    localparam logic [SIZE_W-1:0] PAYLOAD_BYTES = 11'd1024;
    localparam logic [WS_W-1:0]   WS_RESET      = 5'd8;
    localparam logic [SEQ_W-1:0]  LR_RESET      = 8'hFF;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [1:0] KIND_VERDICT = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_DELIVER = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
        logic [SIZE_W-1:0] size;
    } slot_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SHIFT = 2'b10
    } state_t;

endpackage

// File: rtl/core/srrw_cell.sv
// One window slot: holds a frame, shifts down, and extends the in-order run.
module srrw_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_window,
    input  logic           run_in,
    input  logic           nz_in,
    input  logic           shift_en,
    input  logic           wr_en,
    input  srrw_pkg::slot_t wr_data,
    input  srrw_pkg::slot_t above,
    output srrw_pkg::slot_t cur,
    output logic           run_out,
    output logic           nz_out
);
    import srrw_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_next;

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        size_next  = size_reg;
        if (shift_en)
        begin
            valid_next = above.valid;
            word_next  = above.word;
            size_next  = above.size;
        end
        else if (wr_en)
        begin
            valid_next = 1'b1;
            word_next  = wr_data.word;
            size_next  = wr_data.size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        size_reg <= size_next;
    end

    assign cur.valid = valid_reg;
    assign cur.word  = word_reg;
    assign cur.size  = size_reg;

    // run: every slot from 0 up to here is filled and inside the window
    assign run_out = run_in & in_window & valid_reg;
    // nz: same, and none of those frames is an end-of-message frame
    assign nz_out  = nz_in & run_out & (size_reg != '0);

endmodule

// File: rtl/core/srrw_window.sv
// Row of slot cells with the in-order run counters.
module srrw_window #(
    parameter int WINDOW_DEPTH = 16,
    parameter int CNT_W        = $clog2(WINDOW_DEPTH + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [CNT_W-1:0]        win_eff,
    input  logic                    shift_en,
    input  logic [WINDOW_DEPTH-1:0] wr_sel,
    input  srrw_pkg::slot_t         wr_data,
    output srrw_pkg::slot_t         head,
    output logic [CNT_W-1:0]        run_cnt,
    output logic [CNT_W-1:0]        nz_cnt
);
    import srrw_pkg::*;

    localparam slot_t EMPTY_SLOT = '0;

    slot_t                   cur   [WINDOW_DEPTH];
    slot_t                   upper [WINDOW_DEPTH];
    logic [WINDOW_DEPTH:0]   run_c;
    logic [WINDOW_DEPTH:0]   nz_c;

    assign run_c[0] = 1'b1;
    assign nz_c[0]  = 1'b1;

    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        if (i + 1 < WINDOW_DEPTH)
        begin : g_mid
            assign upper[i] = cur[i + 1];
        end
        else
        begin : g_top
            assign upper[i] = EMPTY_SLOT;
        end

        srrw_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_window (32'(i) < 32'(win_eff)),
            .run_in    (run_c[i]),
            .nz_in     (nz_c[i]),
            .shift_en  (shift_en),
            .wr_en     (wr_sel[i]),
            .wr_data   (wr_data),
            .above     (upper[i]),
            .cur       (cur[i]),
            .run_out   (run_c[i + 1]),
            .nz_out    (nz_c[i + 1])
        );
    end

    assign head    = cur[0];
    assign run_cnt = CNT_W'($countones(run_c[WINDOW_DEPTH:1]));
    assign nz_cnt  = CNT_W'($countones(nz_c[WINDOW_DEPTH:1]));

endmodule

// File: rtl/core/selective_repeat_receive_window_top.sv
// Frame item: verdict registered at the accept edge.
// Round tick: the ack is registered at the accept edge, then the slot row shifts one cell a cycle,
// once per frame in the in-order run (released or not), a delivery riding on each shift until the
// releasable frames are out; a stalled output pauses the shifts that carry a delivery.
// Output register decouples the result side; a stalled output holds off new items.
// Reset (async, active low): window 8, last_received 255, all slots empty, no message end.
module selective_repeat_receive_window_top #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [srrw_pkg::WS_W-1:0]   cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        op,
    input  logic                        frame_is_ack,
    input  logic [srrw_pkg::SEQ_W-1:0]  seq_number,
    input  logic [srrw_pkg::WORD_W-1:0] payload_word,
    input  logic [srrw_pkg::SIZE_W-1:0] payload_size,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  kind,
    output logic                        accepted,
    output logic [srrw_pkg::SEQ_W-1:0]  ack_number,
    output logic [srrw_pkg::WORD_W-1:0] delivered_word,
    output logic [srrw_pkg::SIZE_W-1:0] delivered_size,
    output logic                        message_end,
    output logic                        last
);
    import srrw_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

    logic [WS_W-1:0]   window_size_reg;
    logic [SEQ_W-1:0]  last_received_reg;
    logic [SEQ_W-1:0]  last_received_next;
    logic              message_done_reg;
    logic              message_done_next;
    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  step_reg;
    logic [CNT_W-1:0]  step_next;
    logic [CNT_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  pos_next;
    logic [CNT_W-1:0]  nd_reg;
    logic [CNT_W-1:0]  nd_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        kind_reg;
    logic [1:0]        kind_next;
    logic              accepted_reg;
    logic              accepted_next;
    logic [SEQ_W-1:0]  ack_number_reg;
    logic [SEQ_W-1:0]  ack_number_next;
    logic [WORD_W-1:0] dword_reg;
    logic [WORD_W-1:0] dword_next;
    logic [SIZE_W-1:0] dsize_reg;
    logic [SIZE_W-1:0] dsize_next;
    logic              mend_reg;
    logic              mend_next;
    logic              last_reg;
    logic              last_next;

    logic [CNT_W-1:0]        win_eff;
    logic [SEQ_W-1:0]        offset;
    logic                    frame_ok;
    logic                    frame_wr;
    logic                    in_acc;
    logic                    out_can_load;
    logic                    shift_en;
    logic [WINDOW_DEPTH-1:0] wr_sel;
    slot_t                   wr_data;
    slot_t                   head;
    logic [CNT_W-1:0]        run_cnt;
    logic [CNT_W-1:0]        nz_cnt;
    logic [CNT_W-1:0]        nd_eff;
    logic                    zero_hit;
    logic                    deliver;
    logic [CNT_W-1:0]        step_inc;

    // clamp window to [1, WINDOW_DEPTH]
    always_comb
    begin
        if (32'(window_size_reg) > 32'(WINDOW_DEPTH))
            win_eff = CNT_W'(WINDOW_DEPTH);
        else if (window_size_reg == '0)
            win_eff = CNT_W'(1);
        else
            win_eff = CNT_W'(window_size_reg);
    end

    assign out_can_load = !out_valid_reg || out_ready;
    assign in_ready     = (state_reg == ST_IDLE) && out_can_load;
    assign in_acc       = in_valid && in_ready;

    assign offset   = seq_number - last_received_reg - 8'd1;
    assign frame_ok = !frame_is_ack && (32'(offset) < 32'(win_eff));
    assign frame_wr = in_acc && (op == OP_FRAME) && frame_ok;

    always_comb
    begin
        for (int i = 0; i < WINDOW_DEPTH; i++)
            wr_sel[i] = frame_wr && (32'(offset) == 32'(i));
    end

    assign wr_data.valid = 1'b1;
    assign wr_data.word  = payload_word;
    assign wr_data.size  = (payload_size > PAYLOAD_BYTES) ? PAYLOAD_BYTES : payload_size;

    // an ended message releases nothing; a zero-size frame in the run ends it
    assign nd_eff   = message_done_reg ? '0 : nz_cnt;
    assign zero_hit = !message_done_reg && (nz_cnt != run_cnt);

    assign deliver  = step_reg < nd_reg;
    assign step_inc = step_reg + CNT_W'(1);
    assign shift_en = (state_reg == ST_SHIFT) && (!deliver || out_can_load);

    srrw_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .CNT_W        (CNT_W)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .win_eff  (win_eff),
        .shift_en (shift_en),
        .wr_sel   (wr_sel),
        .wr_data  (wr_data),
        .head     (head),
        .run_cnt  (run_cnt),
        .nz_cnt   (nz_cnt)
    );

    always_comb
    begin
        last_received_next = last_received_reg;
        message_done_next  = message_done_reg;
        state_next         = state_reg;
        step_next          = step_reg;
        pos_next           = pos_reg;
        nd_next            = nd_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        kind_next          = kind_reg;
        accepted_next      = accepted_reg;
        ack_number_next    = ack_number_reg;
        dword_next         = dword_reg;
        dsize_next         = dsize_reg;
        mend_next          = mend_reg;
        last_next          = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    out_valid_next  = 1'b1;
                    accepted_next   = 1'b0;
                    ack_number_next = '0;
                    dword_next      = '0;
                    dsize_next      = '0;
                    if (op == OP_FRAME)
                    begin
                        kind_next     = KIND_VERDICT;
                        accepted_next = frame_ok;
                        mend_next     = message_done_reg;
                        last_next     = 1'b1;
                    end
                    else
                    begin
                        last_received_next = last_received_reg + SEQ_W'(run_cnt);
                        message_done_next  = message_done_reg | zero_hit;
                        kind_next          = KIND_ACK;
                        ack_number_next    = last_received_next;
                        mend_next          = message_done_next;
                        last_next          = (nd_eff == '0);
                        pos_next           = run_cnt;
                        nd_next            = nd_eff;
                        step_next          = '0;
                        if (run_cnt != '0)
                            state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (shift_en)
                begin
                    if (deliver)
                    begin
                        out_valid_next  = 1'b1;
                        kind_next       = KIND_DELIVER;
                        accepted_next   = 1'b0;
                        ack_number_next = '0;
                        dword_next      = head.word;
                        dsize_next      = head.size;
                        mend_next       = message_done_reg;
                        last_next       = (step_inc == nd_reg);
                    end
                    step_next = step_inc;
                    if (step_inc == pos_reg)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg   <= WS_RESET;
            last_received_reg <= LR_RESET;
            message_done_reg  <= 1'b0;
            state_reg         <= ST_IDLE;
            step_reg          <= '0;
            pos_reg           <= '0;
            nd_reg            <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                window_size_reg <= cfg_wr_data;
            last_received_reg <= last_received_next;
            message_done_reg  <= message_done_next;
            state_reg         <= state_next;
            step_reg          <= step_next;
            pos_reg           <= pos_next;
            nd_reg            <= nd_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        accepted_reg   <= accepted_next;
        ack_number_reg <= ack_number_next;
        dword_reg      <= dword_next;
        dsize_reg      <= dsize_next;
        mend_reg       <= mend_next;
        last_reg       <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign accepted       = accepted_reg;
    assign ack_number     = ack_number_reg;
    assign delivered_word = dword_reg;
    assign delivered_size = dsize_reg;
    assign message_end    = mend_reg;
    assign last           = last_reg;

endmodule

// File: rtl/core/srrw_checker.sv
// Port-level checks for the receive window, bound to the top level.
`include "assert_macros.svh"

module srrw_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cfg_wr_en,
    input logic [srrw_pkg::WS_W-1:0]   cfg_wr_data,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        op,
    input logic                        frame_is_ack,
    input logic [srrw_pkg::SEQ_W-1:0]  seq_number,
    input logic [srrw_pkg::WORD_W-1:0] payload_word,
    input logic [srrw_pkg::SIZE_W-1:0] payload_size,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [1:0]                  kind,
    input logic                        accepted,
    input logic [srrw_pkg::SEQ_W-1:0]  ack_number,
    input logic [srrw_pkg::WORD_W-1:0] delivered_word,
    input logic [srrw_pkg::SIZE_W-1:0] delivered_size,
    input logic                        message_end,
    input logic                        last
);
    import srrw_pkg::*;

    // a stalled result holds
    `SRRW_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(last))
    // an end-of-message frame is never delivered
    `SRRW_ASSERT_IMP(a_no_zero_deliver, out_valid && kind == KIND_DELIVER, delivered_size != '0)
    // a verdict is always the only result of its item
    `SRRW_ASSERT_IMP(a_verdict_last, out_valid && kind == KIND_VERDICT, last)
    // an acknowledgement frame is never stored
    `SRRW_ASSERT_NXT(a_ack_rejected, in_valid && in_ready && op == OP_FRAME && frame_is_ack, !accepted)
    // the input is ready only while the result register is free or being read
    `SRRW_ASSERT_IMP(a_ready_free, in_ready, !out_valid || out_ready)

endmodule

bind selective_repeat_receive_window_top srrw_checker u_srrw_checker (.*);
